/* hw/rtl/rmt_pkg.sv */
`default_nettype none

package rmt_pkg;

    // Default number of leaves; the top level hands its parameter down.
    localparam int LEAVES_DEFAULT = 1024;

    // Fixed field widths of the transaction ports.
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;

    // Nodes hold values with the sign bit flipped, so unsigned compares order them.
    localparam logic [DATA_W-1:0] SIGN_BIT   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] BIASED_MAX = 32'hFFFF_FFFF;

    // Transaction kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_write;
        logic load;
        logic leaf_write;
        logic sib_read;
        logic anc_update;
        logic lo_read;
        logic hi_read;
        logic acc_update;
        logic shift;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic write_ok;
        logic query_ok;
        logic lo_lt_hi;
        logic lo_odd;
        logic hi_odd;
        logic parent_root;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/rmt_ram.sv */
`default_nettype none

module rmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rmt_datapath.sv */
`default_nettype none

module rmt_datapath #(
    parameter int LEAVES = rmt_pkg::LEAVES_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rmt_pkg::cmd_t                   cmd,
    output rmt_pkg::status_t                     status,
    input  wire logic [rmt_pkg::IDX_W-1:0]       first_index,
    input  wire logic [rmt_pkg::IDX_W-1:0]       last_index,
    input  wire logic signed [rmt_pkg::DATA_W-1:0] new_value,
    output logic signed [rmt_pkg::DATA_W-1:0]    range_min
);

    localparam int NODES  = 2 * LEAVES;
    localparam int NODE_W = $clog2(NODES);
    localparam int HW     = NODE_W + 1;
    localparam int WIDE_W = rmt_pkg::IDX_W + HW;

    logic [NODE_W-1:0]          node_reg, node_next;
    logic [rmt_pkg::DATA_W-1:0] cur_reg, cur_next;
    logic [HW-1:0]              lo_reg, lo_next;
    logic [HW-1:0]              hi_reg, hi_next;
    logic [rmt_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic [NODE_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [rmt_pkg::DATA_W-1:0] range_min_reg, range_min_next;

    logic [WIDE_W-1:0]          first_w, last_w, leaves_w, last_clamp_w;
    logic [NODE_W-1:0]          parent;
    logic [HW-1:0]              hi_dec;
    logic [rmt_pkg::DATA_W-1:0] rd_data, anc_min, acc_min;

    logic                       wr_en, rd_en;
    logic [NODE_W-1:0]          wr_addr, rd_addr;
    logic [rmt_pkg::DATA_W-1:0] wr_data;

    // Input range checks, done wide enough that no leaf count truncates the index.
    assign first_w      = WIDE_W'(first_index);
    assign last_w       = WIDE_W'(last_index);
    assign leaves_w     = WIDE_W'(LEAVES);
    assign last_clamp_w = (last_w >= leaves_w) ? (leaves_w - WIDE_W'(1)) : last_w;

    assign parent  = node_reg >> 1;
    assign hi_dec  = hi_reg - HW'(1);
    assign anc_min = (rd_data < cur_reg) ? rd_data : cur_reg;
    assign acc_min = (rd_data < acc_reg) ? rd_data : acc_reg;

    assign status.clr_done    = (clr_cnt_reg == {NODE_W{1'b1}});
    assign status.write_ok    = (first_w < leaves_w);
    assign status.query_ok    = (first_w < leaves_w) && (first_w <= last_clamp_w);
    assign status.lo_lt_hi    = (lo_reg < hi_reg);
    assign status.lo_odd      = lo_reg[0];
    assign status.hi_odd      = hi_reg[0];
    assign status.parent_root = (parent == NODE_W'(1));

    // Node memory port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = rmt_pkg::BIASED_MAX;
        if (cmd.clr_write)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.leaf_write)
        begin
            wr_en   = 1'b1;
            wr_addr = node_reg;
            wr_data = cur_reg;
        end
        else if (cmd.anc_update)
        begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = anc_min;
        end

        rd_en   = cmd.sib_read | cmd.lo_read | cmd.hi_read;
        rd_addr = {node_reg[NODE_W-1:1], ~node_reg[0]};
        if (cmd.lo_read)
        begin
            rd_addr = lo_reg[NODE_W-1:0];
        end
        else if (cmd.hi_read)
        begin
            rd_addr = hi_dec[NODE_W-1:0];
        end
    end

    always_comb
    begin
        node_next      = node_reg;
        cur_next       = cur_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        acc_next       = acc_reg;
        clr_cnt_next   = clr_cnt_reg;
        range_min_next = range_min_reg;

        if (cmd.clr_write)
        begin
            clr_cnt_next = clr_cnt_reg + NODE_W'(1);
        end
        if (cmd.load)
        begin
            node_next = NODE_W'(first_w + leaves_w);
            cur_next  = $unsigned(new_value) ^ rmt_pkg::SIGN_BIT;
            lo_next   = HW'(first_w + leaves_w);
            hi_next   = HW'(last_clamp_w + leaves_w + WIDE_W'(1));
            acc_next  = rmt_pkg::BIASED_MAX;
        end
        if (cmd.anc_update)
        begin
            cur_next  = anc_min;
            node_next = parent;
        end
        if (cmd.lo_read)
        begin
            lo_next = lo_reg + HW'(1);
        end
        if (cmd.hi_read)
        begin
            hi_next = hi_dec;
        end
        if (cmd.acc_update)
        begin
            acc_next = acc_min;
        end
        if (cmd.shift)
        begin
            lo_next = lo_reg >> 1;
            hi_next = hi_reg >> 1;
        end
        if (cmd.out_load)
        begin
            range_min_next = acc_reg ^ rmt_pkg::SIGN_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        cur_reg       <= cur_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        acc_reg       <= acc_next;
        range_min_reg <= range_min_next;
    end

    assign range_min = $signed(range_min_reg);

    rmt_ram #(
        .WIDTH (rmt_pkg::DATA_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

/* hw/rtl/rmt_ctrl.sv */
`default_nettype none

module rmt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             kind,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire rmt_pkg::status_t status,
    output rmt_pkg::cmd_t         cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_W_LEAF = 4'd2;
    localparam logic [3:0] S_W_READ = 4'd3;
    localparam logic [3:0] S_W_UPD  = 4'd4;
    localparam logic [3:0] S_Q_TEST = 4'd5;
    localparam logic [3:0] S_Q_LO   = 4'd6;
    localparam logic [3:0] S_Q_HI   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (kind == rmt_pkg::KIND_QUERY)
                    begin
                        state_next = status.query_ok ? S_Q_TEST : S_DONE;
                    end
                    else
                    begin
                        state_next = status.write_ok ? S_W_LEAF : S_IDLE;
                    end
                end
            end
            S_W_LEAF:
            begin
                cmd.leaf_write = 1'b1;
                state_next     = S_W_READ;
            end
            S_W_READ:
            begin
                cmd.sib_read = 1'b1;
                state_next   = S_W_UPD;
            end
            S_W_UPD:
            begin
                cmd.anc_update = 1'b1;
                state_next     = status.parent_root ? S_IDLE : S_W_READ;
            end
            S_Q_TEST:
            begin
                if (!status.lo_lt_hi)
                begin
                    state_next = S_DONE;
                end
                else if (status.lo_odd)
                begin
                    cmd.lo_read = 1'b1;
                    state_next  = S_Q_LO;
                end
                else if (status.hi_odd)
                begin
                    cmd.hi_read = 1'b1;
                    state_next  = S_Q_HI;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            S_Q_LO:
            begin
                cmd.acc_update = 1'b1;
                if (status.hi_odd)
                begin
                    cmd.hi_read = 1'b1;
                    state_next  = S_Q_HI;
                end
                else
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_Q_TEST;
                end
            end
            S_Q_HI:
            begin
                cmd.acc_update = 1'b1;
                cmd.shift      = 1'b1;
                state_next     = S_Q_TEST;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/range_minimum_tree_top.sv */
// Transactions are handled one at a time; a query's result then goes to the output
// register, and a new transaction is accepted only once the last one is through.
// Reset: asynchronous, active low; afterwards a clearing pass fills every node
// with the maximum value while the input is stalled.
`default_nettype none

module range_minimum_tree_top #(
    parameter int LEAVES = rmt_pkg::LEAVES_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              kind,
    input  wire logic [rmt_pkg::IDX_W-1:0]         first_index,
    input  wire logic [rmt_pkg::IDX_W-1:0]         last_index,
    input  wire logic signed [rmt_pkg::DATA_W-1:0] new_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [rmt_pkg::DATA_W-1:0]      range_min
);

    // The tree lives in one node memory of 2*LEAVES entries. Node 1 is the
    // root, node i has children 2i and 2i+1, and leaf p sits at LEAVES+p.
    // Values are stored with the sign bit flipped so that the minimum is an
    // unsigned compare.
    //
    // A write transaction stores the leaf, then climbs one level at a time:
    // it reads the sibling of the current node and writes the
    // minimum of that sibling and the value carried up into the parent.
    //
    // A query transaction walks a half-open node interval towards the root,
    // reading at most the left and the right boundary node at each level and
    // folding them into an accumulator. Empty, inverted or out-of-range
    // queries skip the walk and report the maximum value.
    //
    // The result sits in an output register, so a waiting result does not
    // block the next transaction from being accepted and worked on.

    rmt_pkg::cmd_t    cmd;
    rmt_pkg::status_t status;

    rmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rmt_datapath #(
        .LEAVES (LEAVES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .first_index (first_index),
        .last_index  (last_index),
        .new_value   (new_value),
        .range_min   (range_min)
    );

endmodule

`default_nettype wire

/* test/range_minimum_tree_top_test.sv */
module range_minimum_tree_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rmt_pkg::*;

    localparam int LEAVES = LEAVES_DEFAULT;
    // The slowest correct run, including the clearing pass, stays well below this limit.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 300;

    // Scoreboard: a shadow segment tree plus the minima that pending queries must return.
    class range_min_tracker;
        // Nodes are kept biased (sign bit flipped) so that unsigned compares order them.
        logic [DATA_W-1:0] nodes [2*LEAVES];
        logic signed [DATA_W-1:0] expected_minima [$];
        int mismatches;

        function new();
            foreach (nodes[i])
                nodes[i] = BIASED_MAX;
            mismatches = 0;
        endfunction

        function void store_leaf(int unsigned pos, logic [DATA_W-1:0] biased);
            int unsigned node;
            if (pos >= LEAVES)
                return;
            node = pos + LEAVES;
            nodes[node] = biased;
            node = node >> 1;
            while (node >= 1) begin
                nodes[node] = (nodes[2*node] < nodes[2*node+1]) ? nodes[2*node]
                                                                : nodes[2*node+1];
                node = node >> 1;
            end
        endfunction

        function logic [DATA_W-1:0] lowest_in_range(int unsigned first, int unsigned last);
            logic [DATA_W-1:0] acc;
            int unsigned lo;
            int unsigned hi;
            acc = BIASED_MAX;
            if (first >= LEAVES)
                return acc;
            if (last >= LEAVES)
                last = LEAVES - 1;
            if (first > last)
                return acc;
            lo = first + LEAVES;
            hi = last + LEAVES + 1;
            while (lo < hi) begin
                if (lo[0]) begin
                    if (nodes[lo] < acc)
                        acc = nodes[lo];
                    lo++;
                end
                if (hi[0]) begin
                    hi--;
                    if (nodes[hi] < acc)
                        acc = nodes[hi];
                end
                lo = lo >> 1;
                hi = hi >> 1;
            end
            return acc;
        endfunction

        function void note_input(logic kind_bit, logic [IDX_W-1:0] first,
                                 logic [IDX_W-1:0] last, logic signed [DATA_W-1:0] value);
            if (kind_bit == KIND_WRITE)
                store_leaf(first, value ^ SIGN_BIT);
            else
                expected_minima.push_back(lowest_in_range(first, last) ^ SIGN_BIT);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] actual);
            logic signed [DATA_W-1:0] want;
            if (expected_minima.size() == 0) begin
                $display("%0t: range_min %0d arrived with no query outstanding", $time, actual);
                mismatches++;
                return;
            end
            want = expected_minima.pop_front();
            if (actual !== want) begin
                $display("%0t: range_min expected %0d actual %0d", $time, want, actual);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_minima.size();
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = KIND_WRITE;
    logic [IDX_W-1:0] first_index = '0;
    logic [IDX_W-1:0] last_index = '0;
    logic signed [DATA_W-1:0] new_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DATA_W-1:0] range_min;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Asks the receiver once for a long hold-off; the receiver counts it down itself.
    logic hold_wanted = 1'b0;
    logic hold_started = 1'b0;
    int hold_left = 0;
    // Start of the leaf window that most random transactions work on.
    int unsigned hot_base = 0;
    int cycle_count = 0;

    range_min_tracker tracker = new();

    range_minimum_tree_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .first_index (first_index),
        .last_index  (last_index),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .range_min   (range_min)
    );

    always
    begin
        #5ns clk = 1'b1;
        #5ns clk = 1'b0;
    end

    // Both channels are sampled at the rising edge, before the nonblocking updates of
    // that edge land, so every transaction is seen with the values that were accepted.
    // A result can never share an edge with the query that causes it, so noting the
    // input first keeps the queue in order.
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            tracker.note_input(kind, first_index, last_index, new_value);
        if (out_valid && !out_stall)
            tracker.check_result(range_min);
    end

    // Receiver: random stalls by phase, plus one long hold-off that lets the block fill
    // up with a finished query so that it has to stall its input.
    always @(posedge clk)
    begin
        if (hold_wanted && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("range_minimum_tree_top test failed");
            $finish;
        end
    end

    // Offers one transaction, after a random number of idle cycles, and returns on the
    // edge at which the block takes it. The valid is only lowered when a gap is taken,
    // so back-to-back transactions keep it high without a second assignment.
    task automatic send_transaction(input logic k, input logic [IDX_W-1:0] f,
                                    input logic [IDX_W-1:0] l,
                                    input logic signed [DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        first_index <= f;
        last_index <= l;
        new_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random transactions mostly stay in a small window of leaves, so that queries see
    // recently written values instead of the global minimum. Ranges come as single
    // points, short spans, inverted spans, spans to the last leaf and random pairs.
    task automatic random_transaction();
        logic k;
        logic [IDX_W-1:0] f;
        logic [IDX_W-1:0] l;
        logic signed [DATA_W-1:0] v;
        if ($urandom_range(63) == 0)
            hot_base = $urandom_range(LEAVES - 1);
        k = ($urandom_range(1) == 1) ? KIND_QUERY : KIND_WRITE;
        if ($urandom_range(3) == 0)
            f = IDX_W'($urandom);
        else
            f = IDX_W'(hot_base + $urandom_range(31));
        case ($urandom_range(7))
            0: l = f;
            1, 2, 3: l = IDX_W'(f + $urandom_range(15));
            4: l = IDX_W'(f - $urandom_range(8) - 1);
            5: l = '1;
            default: l = IDX_W'($urandom);
        endcase
        case ($urandom_range(9))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7FFF_FFFF;
            2: v = '0;
            3: v = '1;
            4, 5: begin
                v = $urandom_range(200);
                v = v - 100;
            end
            default: v = $urandom;
        endcase
        send_transaction(k, f, l, v);
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with gentle idling on both sides. The block is still clearing
        // its nodes after reset, which the sender simply waits out on the stall.
        send_idle_pct <= 28;
        recv_stall_pct <= 48;
        // The untouched tree returns the maximum everywhere, and so does an inverted range.
        send_transaction(KIND_QUERY, 10'd0, 10'd1023, '0);
        send_transaction(KIND_QUERY, 10'd5, 10'd3, '0);
        // Extreme values at the two outermost leaves; last_index must not matter.
        send_transaction(KIND_WRITE, 10'd0, 10'd1023, 32'sh8000_0000);
        send_transaction(KIND_QUERY, 10'd0, 10'd0, '0);
        send_transaction(KIND_QUERY, 10'd1, 10'd1023, '0);
        send_transaction(KIND_WRITE, 10'd1023, 10'd0, 32'sh7FFF_FFFF);
        send_transaction(KIND_WRITE, 10'd1023, 10'd512, -32'sd1);
        send_transaction(KIND_QUERY, 10'd1023, 10'd1023, '0);
        send_transaction(KIND_QUERY, 10'd512, 10'd1023, '0);
        send_transaction(KIND_WRITE, 10'd511, 10'd511, '0);
        send_transaction(KIND_QUERY, 10'd1, 10'd1023, '0);
        send_transaction(KIND_QUERY, 10'd0, 10'd1023, 32'sh7FFF_FFFF);
        send_transaction(KIND_QUERY, 10'd1023, 10'd0, '0);
        // Writing the maximum back restores the leaf to its reset value.
        send_transaction(KIND_WRITE, 10'd0, 10'd1023, 32'sh7FFF_FFFF);
        send_transaction(KIND_QUERY, 10'd0, 10'd511, '0);
        send_transaction(KIND_QUERY, 10'd0, 10'd1022, '0);
        send_transaction(KIND_WRITE, 10'd300, 10'd5, 32'sd12345);
        send_transaction(KIND_QUERY, 10'd300, 10'd300, '0);
        send_transaction(KIND_QUERY, 10'd1022, 10'd1023, '0);
        send_transaction(KIND_QUERY, 10'd301, 10'd510, '0);
        send_transaction(KIND_QUERY, 10'd299, 10'd299, '0);

        // Random part in three phases: receiver stalls more, then sender idles more,
        // then full speed with one long receiver hold-off at its start.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct <= 28;
                    recv_stall_pct <= 48;
                end
                1: begin
                    send_idle_pct <= 48;
                    recv_stall_pct <= 28;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_stall_pct <= 0;
                    hold_wanted <= 1'b1;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
                random_transaction();
        end
        in_valid <= 1'b0;

        // Drain the outstanding queries, then give a late or extra result time to show.
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (tracker.mismatches == 0)
            $display("range_minimum_tree_top test passed");
        else
            $display("range_minimum_tree_top test failed");
        $finish;
    end

endmodule

/* range_minimum_tree_top.f */
hw/rtl/rmt_pkg.sv
hw/rtl/rmt_ram.sv
hw/rtl/rmt_datapath.sv
hw/rtl/rmt_ctrl.sv
hw/rtl/range_minimum_tree_top.sv
test/range_minimum_tree_top_test.sv
